[src/sdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared widths, register indexes, reset values and payload types of the
// stick to drive command unit.
// ----------------------------------------------------------------------------
package sdc_pkg;

	localparam int AXIS_BITS      = 16;
	localparam int DZ_BITS        = 15;
	localparam int LIMIT_BITS     = 15;
	localparam int GAIN_BITS      = 16;
	localparam int MEAS_BITS      = 16;
	localparam int CMD_BITS       = 16;
	localparam int ERR_BITS       = MEAS_BITS + 1;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// Deadzone ceiling, 0.99 of full scale in Q0.15
	localparam logic [DZ_BITS-1:0] DZ_MAX = 15'd32440;

	localparam logic [DZ_BITS-1:0]    RST_DEADZONE          = 15'd3277;
	localparam logic [LIMIT_BITS-1:0] RST_STEER_ANGLE_LIMIT = 15'd2048;
	localparam logic [GAIN_BITS-1:0]  RST_SPEED_GAIN        = 16'd256;
	localparam logic [GAIN_BITS-1:0]  RST_STEER_GAIN        = 16'd256;
	localparam logic [LIMIT_BITS-1:0] RST_ACCEL_LIMIT       = 15'd512;
	localparam logic [LIMIT_BITS-1:0] RST_DECEL_LIMIT       = 15'd768;
	localparam logic [LIMIT_BITS-1:0] RST_BRAKE_DECEL_LIMIT = 15'd1536;
	localparam logic [LIMIT_BITS-1:0] RST_STEER_RATE_LIMIT  = 15'd2048;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DEADZONE          = 3'd0,
		REG_STEER_ANGLE_LIMIT = 3'd1,
		REG_SPEED_GAIN        = 3'd2,
		REG_STEER_GAIN        = 3'd3,
		REG_ACCEL_LIMIT       = 3'd4,
		REG_DECEL_LIMIT       = 3'd5,
		REG_BRAKE_DECEL_LIMIT = 3'd6,
		REG_STEER_RATE_LIMIT  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [AXIS_BITS-1:0] speed_stick;
		logic signed [AXIS_BITS-1:0] steer_stick;
		logic                        brake_button;
		logic                        axes_valid;
		logic [LIMIT_BITS-1:0]       speed_limit;
		logic signed [MEAS_BITS-1:0] measured_speed;
		logic signed [MEAS_BITS-1:0] measured_steer;
	} stick_t;

	typedef struct packed {
		logic signed [CMD_BITS-1:0] accel_cmd;
		logic signed [CMD_BITS-1:0] steer_rate_cmd;
		logic                       brake_active;
	} drive_t;

	typedef struct packed {
		logic brake;
		logic axes_ok;
	} flags_t;

	typedef struct packed {
		flags_t                flags;
		logic [LIMIT_BITS-1:0] speed_limit;
		logic [MEAS_BITS-1:0]  measured_speed;
		logic [MEAS_BITS-1:0]  measured_steer;
	} side_t;

endpackage

[src/stick_to_drive_command_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_to_drive_command_unit
// Turns stick positions, brake button and measured vehicle state into
// clamped acceleration and steering rate commands.
// ----------------------------------------------------------------------------
// Usage:
//   stick channel (stick_valid / stick_stall / stick): one sample set per
//   transfer. drive channel (drive_valid / drive_stall / drive): one command
//   per sample set, in order. cfg channel (cfg_valid / cfg_ready, always
//   ready): writes register cfg_index with cfg_data; change it only while no
//   sample set is in flight.
//   Throughput is one sample set per cycle while no command is held by
//   drive_stall; the deadzone renormalising divider is pipelined and
//   resolves one quotient bit per stage, AXIS_BITS stages per axis.
//   While a command waits with drive_stall high the whole pipeline holds and
//   stick_stall is raised; nothing is dropped or repeated.
//   Reset clears every stage valid bit and loads the registers with their
//   default values; a sample set may follow reset on the first clock.
// ----------------------------------------------------------------------------
module stick_to_drive_command_unit #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                stick_valid,
	output logic                                stick_stall,
	input  sdc_pkg::stick_t                     stick,
	output logic                                drive_valid,
	input  logic                                drive_stall,
	output sdc_pkg::drive_t                     drive,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sdc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sdc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import sdc_pkg::*;

	localparam int FRAC           = AXIS_BITS - 1;
	localparam int DZ_WIDE_BITS   = DZ_BITS + FRAC;
	localparam int TGT_PROD_BITS  = FRAC + LIMIT_BITS;
	localparam int GAIN_PROD_BITS = MEAS_BITS + GAIN_BITS;
	localparam int SCALED_BITS    = GAIN_PROD_BITS - GAIN_FRAC_BITS;
	localparam int DIV_STEPS      = AXIS_BITS;
	localparam int LAST           = DIV_STEPS - 1;

	localparam logic [AXIS_BITS-1:0] FULL_SCALE = {1'b1, {FRAC{1'b0}}};
	localparam logic [FRAC-1:0]      AXIS_MAX   = {FRAC{1'b1}};

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [DZ_BITS-1:0]    deadzone_q;
	logic [LIMIT_BITS-1:0] steer_angle_limit_q;
	logic [GAIN_BITS-1:0]  speed_gain_q;
	logic [GAIN_BITS-1:0]  steer_gain_q;
	logic [LIMIT_BITS-1:0] accel_limit_q;
	logic [LIMIT_BITS-1:0] decel_limit_q;
	logic [LIMIT_BITS-1:0] brake_decel_limit_q;
	logic [LIMIT_BITS-1:0] steer_rate_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q          <= RST_DEADZONE;
			steer_angle_limit_q <= RST_STEER_ANGLE_LIMIT;
			speed_gain_q        <= RST_SPEED_GAIN;
			steer_gain_q        <= RST_STEER_GAIN;
			accel_limit_q       <= RST_ACCEL_LIMIT;
			decel_limit_q       <= RST_DECEL_LIMIT;
			brake_decel_limit_q <= RST_BRAKE_DECEL_LIMIT;
			steer_rate_limit_q  <= RST_STEER_RATE_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEADZONE:          deadzone_q          <= cfg_data[DZ_BITS-1:0];
				REG_STEER_ANGLE_LIMIT: steer_angle_limit_q <= cfg_data[LIMIT_BITS-1:0];
				REG_SPEED_GAIN:        speed_gain_q        <= cfg_data[GAIN_BITS-1:0];
				REG_STEER_GAIN:        steer_gain_q        <= cfg_data[GAIN_BITS-1:0];
				REG_ACCEL_LIMIT:       accel_limit_q       <= cfg_data[LIMIT_BITS-1:0];
				REG_DECEL_LIMIT:       decel_limit_q       <= cfg_data[LIMIT_BITS-1:0];
				REG_BRAKE_DECEL_LIMIT: brake_decel_limit_q <= cfg_data[LIMIT_BITS-1:0];
				REG_STEER_RATE_LIMIT:  steer_rate_limit_q  <= cfg_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Deadzone on the axis scale and the renormalising divisor. Both are
	// registered from the deadzone register, well before any sample needs them.
	logic [DZ_BITS-1:0]      dz_clamped;
	logic [DZ_WIDE_BITS-1:0] dz_wide;
	logic [FRAC-1:0]         dz_q;
	logic [AXIS_BITS-1:0]    den_q;

	always_comb begin
		dz_clamped = (deadzone_q > DZ_MAX) ? DZ_MAX : deadzone_q;
		dz_wide    = {dz_clamped, {FRAC{1'b0}}};
	end

	always_ff @(posedge clk) begin
		dz_q  <= dz_wide[DZ_WIDE_BITS-1:DZ_BITS];
		den_q <= FULL_SCALE - {1'b0, dz_wide[DZ_WIDE_BITS-1:DZ_BITS]};
	end

	// ------------------------------------------------------------------
	// Flow control: every stage advances together unless the finished
	// command is held by the receiver.
	// ------------------------------------------------------------------
	logic adv;

	assign adv         = !(drive_valid && drive_stall);
	assign stick_stall = !adv;

	// ------------------------------------------------------------------
	// Stage 1: capture the sample set
	// ------------------------------------------------------------------
	logic   vld_s1;
	stick_t stick_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= stick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stick_s1 <= stick;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: magnitude and distance past the deadzone (lane 0 speed,
	// lane 1 steering). Inside the deadzone the distance is zero, which
	// the divider turns into a zero axis value.
	// ------------------------------------------------------------------
	logic [AXIS_BITS-1:0] axis_raw [2];
	logic [AXIS_BITS-1:0] mag_d    [2];
	logic [AXIS_BITS-1:0] dmag_d   [2];
	side_t                side_d;

	always_comb begin
		axis_raw[0] = stick_s1.speed_stick;
		axis_raw[1] = stick_s1.steer_stick;
		for (int l = 0; l < 2; l++) begin
			mag_d[l]  = axis_raw[l][AXIS_BITS-1] ? -axis_raw[l] : axis_raw[l];
			dmag_d[l] = (mag_d[l] > {1'b0, dz_q}) ? mag_d[l] - {1'b0, dz_q} : '0;
		end
		side_d.flags.brake    = stick_s1.brake_button;
		side_d.flags.axes_ok  = stick_s1.axes_valid;
		side_d.speed_limit    = stick_s1.speed_limit;
		side_d.measured_speed = stick_s1.measured_speed;
		side_d.measured_steer = stick_s1.measured_steer;
	end

	logic                 vld_s2;
	side_t                side_s2;
	logic [AXIS_BITS-1:0] dmag_s2 [2];
	logic                 neg_s2  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_d;
			for (int l = 0; l < 2; l++) begin
				dmag_s2[l] <= dmag_d[l];
				neg_s2[l]  <= axis_raw[l][AXIS_BITS-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: restoring division dmag * 2^FRAC / den, one quotient bit per
	// sub-stage. dmag never exceeds den, so the first step settles the top
	// bit and the remainder stays below den throughout.
	// ------------------------------------------------------------------
	logic [FRAC-1:0]      rem_d  [DIV_STEPS][2];
	logic [AXIS_BITS-1:0] quo_d  [DIV_STEPS][2];
	logic [FRAC-1:0]      rem_s3 [DIV_STEPS][2];
	logic [AXIS_BITS-1:0] quo_s3 [DIV_STEPS][2];
	logic                 neg_s3 [DIV_STEPS][2];
	side_t                side_s3 [DIV_STEPS];
	logic                 vld_s3  [DIV_STEPS];

	always_comb begin
		logic [AXIS_BITS-1:0] part;
		logic [AXIS_BITS-1:0] diff;
		logic                 ge;
		for (int l = 0; l < 2; l++) begin
			part        = dmag_s2[l];
			ge          = (part >= den_q);
			diff        = part - den_q;
			rem_d[0][l] = ge ? diff[FRAC-1:0] : part[FRAC-1:0];
			quo_d[0][l] = {{FRAC{1'b0}}, ge};
		end
		for (int k = 1; k < DIV_STEPS; k++) begin
			for (int l = 0; l < 2; l++) begin
				part        = {rem_s3[k-1][l], 1'b0};
				ge          = (part >= den_q);
				diff        = part - den_q;
				rem_d[k][l] = ge ? diff[FRAC-1:0] : part[FRAC-1:0];
				quo_d[k][l] = {quo_s3[k-1][l][FRAC-1:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				vld_s3[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s3[0] <= vld_s2;
			for (int k = 1; k < DIV_STEPS; k++) begin
				vld_s3[k] <= vld_s3[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s3     <= rem_d;
			quo_s3     <= quo_d;
			side_s3[0] <= side_s2;
			neg_s3[0]  <= neg_s2;
			for (int k = 1; k < DIV_STEPS; k++) begin
				side_s3[k] <= side_s3[k-1];
				neg_s3[k]  <= neg_s3[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: saturate the quotient; full scale exactly maps one below
	// ------------------------------------------------------------------
	logic            vld_s4;
	side_t           side_s4;
	logic [FRAC-1:0] mag_s4 [2];
	logic            neg_s4 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3[LAST];
			for (int l = 0; l < 2; l++) begin
				mag_s4[l] <= quo_s3[LAST][l][AXIS_BITS-1] ? AXIS_MAX
				                                           : quo_s3[LAST][l][FRAC-1:0];
				neg_s4[l] <= neg_s3[LAST][l];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: stick magnitude times speed limit / maximum angle
	// ------------------------------------------------------------------
	logic                     vld_s5;
	side_t                    side_s5;
	logic [TGT_PROD_BITS-1:0] prod_s5 [2];
	logic                     neg_s5  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5    <= side_s4;
			neg_s5     <= neg_s4;
			prod_s5[0] <= TGT_PROD_BITS'(mag_s4[0]) * TGT_PROD_BITS'(side_s4.speed_limit);
			prod_s5[1] <= TGT_PROD_BITS'(mag_s4[1]) * TGT_PROD_BITS'(steer_angle_limit_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: targets (truncated magnitudes, sign restored) and errors.
	// Forward is a negative speed stick, so the speed target takes the
	// opposite sign; braking drops the speed target to zero.
	// ------------------------------------------------------------------
	logic [LIMIT_BITS-1:0] tgt_mag [2];
	logic [MEAS_BITS-1:0]  tgt_pos [2];
	logic [MEAS_BITS-1:0]  tgt_speed;
	logic [MEAS_BITS-1:0]  tgt_steer;
	logic [ERR_BITS-1:0]   err_d [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			tgt_mag[l] = prod_s5[l][TGT_PROD_BITS-1:FRAC];
			tgt_pos[l] = MEAS_BITS'(tgt_mag[l]);
		end
		if (side_s5.flags.brake) begin
			tgt_speed = '0;
		end else begin
			tgt_speed = neg_s5[0] ? tgt_pos[0] : -tgt_pos[0];
		end
		tgt_steer = neg_s5[1] ? -tgt_pos[1] : tgt_pos[1];
		err_d[0]  = {tgt_speed[MEAS_BITS-1], tgt_speed}
		          - {side_s5.measured_speed[MEAS_BITS-1], side_s5.measured_speed};
		err_d[1]  = {tgt_steer[MEAS_BITS-1], tgt_steer}
		          - {side_s5.measured_steer[MEAS_BITS-1], side_s5.measured_steer};
	end

	logic                vld_s6;
	flags_t              flags_s6;
	logic [ERR_BITS-1:0] err_s6 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s6 <= side_s5.flags;
			err_s6   <= err_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: error magnitude and sign
	// ------------------------------------------------------------------
	logic [ERR_BITS-1:0]  err_neg [2];
	logic                 vld_s7;
	flags_t               flags_s7;
	logic [MEAS_BITS-1:0] emag_s7 [2];
	logic                 eneg_s7 [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			err_neg[l] = -err_s6[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s7 <= flags_s6;
			for (int l = 0; l < 2; l++) begin
				eneg_s7[l] <= err_s6[l][ERR_BITS-1];
				emag_s7[l] <= err_s6[l][ERR_BITS-1] ? err_neg[l][MEAS_BITS-1:0]
				                                     : err_s6[l][MEAS_BITS-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: error magnitude times gain
	// ------------------------------------------------------------------
	logic                      vld_s8;
	flags_t                    flags_s8;
	logic [GAIN_PROD_BITS-1:0] gprod_s8 [2];
	logic                      eneg_s8  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s8    <= flags_s7;
			eneg_s8     <= eneg_s7;
			gprod_s8[0] <= GAIN_PROD_BITS'(emag_s7[0]) * GAIN_PROD_BITS'(speed_gain_q);
			gprod_s8[1] <= GAIN_PROD_BITS'(emag_s7[1]) * GAIN_PROD_BITS'(steer_gain_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: drop the gain fraction and clamp the magnitude to the limit
	// of its side. A negative speed error takes the decel limit, the brake one when braking.
	// ------------------------------------------------------------------
	logic [SCALED_BITS-1:0] scaled  [2];
	logic [LIMIT_BITS-1:0]  lim     [2];
	logic [LIMIT_BITS-1:0]  cmag_d  [2];

	always_comb begin
		if (!eneg_s8[0]) begin
			lim[0] = accel_limit_q;
		end else if (flags_s8.brake) begin
			lim[0] = brake_decel_limit_q;
		end else begin
			lim[0] = decel_limit_q;
		end
		lim[1] = steer_rate_limit_q;
		for (int l = 0; l < 2; l++) begin
			scaled[l] = gprod_s8[l][GAIN_PROD_BITS-1:GAIN_FRAC_BITS];
			cmag_d[l] = (scaled[l] > SCALED_BITS'(lim[l])) ? lim[l]
			                                               : scaled[l][LIMIT_BITS-1:0];
		end
	end

	logic                  vld_s9;
	flags_t                flags_s9;
	logic [LIMIT_BITS-1:0] cmag_s9 [2];
	logic                  eneg_s9 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s9 <= flags_s8;
			eneg_s9  <= eneg_s8;
			cmag_s9  <= cmag_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: output register. Restore the sign; missing stick data
	// forces both commands to zero but still reports the brake.
	// ------------------------------------------------------------------
	logic [CMD_BITS-1:0] cmd_pos [2];
	logic [CMD_BITS-1:0] cmd_d   [2];
	logic                vld_s10;
	drive_t              drive_s10;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cmd_pos[l] = CMD_BITS'(cmag_s9[l]);
			if (!flags_s9.axes_ok) begin
				cmd_d[l] = '0;
			end else begin
				cmd_d[l] = eneg_s9[l] ? -cmd_pos[l] : cmd_pos[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_s10.accel_cmd      <= cmd_d[0];
			drive_s10.steer_rate_cmd <= cmd_d[1];
			drive_s10.brake_active   <= flags_s9.brake;
		end
	end

	assign drive_valid = vld_s10;
	assign drive       = drive_s10;

endmodule

[src/sdc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_checker
// Port level checks of the stick to drive command unit, bound to its top.
// ----------------------------------------------------------------------------
module sdc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                stick_stall,
	input logic                                drive_valid,
	input logic                                drive_stall,
	input sdc_pkg::drive_t                     drive,
	input logic                                cfg_valid,
	input logic                                cfg_ready
);
	import sdc_pkg::*;

	// A held command stays valid and unchanged
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("drive command changed while stalled");

	// Input is only held back by a stalled command
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		stick_stall |-> drive_valid && drive_stall)
		else $error("stick channel stalled without a held command");

	// Clamped commands never reach the most negative code
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive.accel_cmd != {1'b1, {(CMD_BITS-1){1'b0}}}
		             && drive.steer_rate_cmd != {1'b1, {(CMD_BITS-1){1'b0}}})
		else $error("command outside the clamp range");

	// Register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind stick_to_drive_command_unit sdc_checker u_sdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.stick_stall (stick_stall),
	.drive_valid (drive_valid),
	.drive_stall (drive_stall),
	.drive       (drive),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);

[dv/stick_to_drive_command_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_to_drive_command_unit_tb
// Self-checking bench for the stick to drive command unit. Sample sets are
// offered with random gaps, drive commands are taken with random stalls, and
// every command is checked against a bit-true prediction held in a
// scoreboard. The run moves through several register settings, written
// over the config channel while the unit is idle.
// ----------------------------------------------------------------------------
module stick_to_drive_command_unit_tb;
	import sdc_pkg::*;

	localparam int GAIN_FRAC    = 8;
	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 12;
	// Settle time at the end, beyond the pipeline depth
	localparam int SETTLE       = AXIS_BITS + 8 + 16;
	localparam int HOLD_CYCLES  = 120;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS  = 130;
	localparam longint RUN_LIMIT_NS = 2_000_000;

	// ------------------------------------------------------------------------
	// Scoreboard: register copy, command predictor, queue of expected commands
	// ------------------------------------------------------------------------
	class drive_command_scoreboard #(int GAIN_FRAC = 8);
		logic [15:0] regs [8];
		drive_t      expected_cmds [$];
		int          errors;
		int          n_sets;
		int          n_brake;
		int          n_invalid;
		int          n_clamped;

		function new();
			regs[REG_DEADZONE]          = 16'(RST_DEADZONE);
			regs[REG_STEER_ANGLE_LIMIT] = 16'(RST_STEER_ANGLE_LIMIT);
			regs[REG_SPEED_GAIN]        = RST_SPEED_GAIN;
			regs[REG_STEER_GAIN]        = RST_STEER_GAIN;
			regs[REG_ACCEL_LIMIT]       = 16'(RST_ACCEL_LIMIT);
			regs[REG_DECEL_LIMIT]       = 16'(RST_DECEL_LIMIT);
			regs[REG_BRAKE_DECEL_LIMIT] = 16'(RST_BRAKE_DECEL_LIMIT);
			regs[REG_STEER_RATE_LIMIT]  = 16'(RST_STEER_RATE_LIMIT);
			errors    = 0;
			n_sets    = 0;
			n_brake   = 0;
			n_invalid = 0;
			n_clamped = 0;
		endfunction

		// Gains are full 16 bit, everything else keeps 15 bits
		function void set_reg(cfg_reg_t idx, logic [15:0] data);
			if (idx == REG_SPEED_GAIN || idx == REG_STEER_GAIN)
				regs[idx] = data;
			else
				regs[idx] = {1'b0, data[14:0]};
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction

		function longint clamped_deadzone();
			return (regs[REG_DEADZONE] > 16'(DZ_MAX)) ? longint'(DZ_MAX)
				: longint'(regs[REG_DEADZONE]);
		endfunction

		// Deadzone then renormalise to full scale, sign kept
		function longint shape_axis(longint v);
			longint fs;
			longint dz;
			longint mag;
			longint n;
			fs  = longint'(1) << (AXIS_BITS - 1);
			dz  = clamped_deadzone() * fs / 32768;
			mag = (v < 0) ? -v : v;
			if (mag <= dz)
				return 0;
			n = (mag - dz) * fs / (fs - dz);
			if (n > fs - 1)
				n = fs - 1;
			return (v < 0) ? -n : n;
		endfunction

		// Multiply and shift right, truncating toward zero
		function longint scale_tz(longint a, longint b, int sh);
			longint mag;
			mag = ((a < 0) ? -a : a) * b;
			mag = mag >> sh;
			return (a < 0) ? -mag : mag;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function drive_t predict_command(stick_t s);
			longint spd_axis;
			longint str_axis;
			longint tgt_spd;
			longint tgt_str;
			longint decel;
			longint raw_acc;
			longint raw_rate;
			longint acc;
			longint rate;
			drive_t c;
			acc  = 0;
			rate = 0;
			if (s.axes_valid) begin
				spd_axis = shape_axis(longint'($signed(s.speed_stick)));
				str_axis = shape_axis(longint'($signed(s.steer_stick)));
				tgt_spd  = s.brake_button ? 0
					: scale_tz(-spd_axis, longint'(s.speed_limit), AXIS_BITS - 1);
				tgt_str  = scale_tz(str_axis, longint'(regs[REG_STEER_ANGLE_LIMIT]),
					AXIS_BITS - 1);
				decel    = s.brake_button ? longint'(regs[REG_BRAKE_DECEL_LIMIT])
					: longint'(regs[REG_DECEL_LIMIT]);
				raw_acc  = scale_tz(tgt_spd - longint'($signed(s.measured_speed)),
					longint'(regs[REG_SPEED_GAIN]), GAIN_FRAC);
				raw_rate = scale_tz(tgt_str - longint'($signed(s.measured_steer)),
					longint'(regs[REG_STEER_GAIN]), GAIN_FRAC);
				acc  = clip(raw_acc, -decel, longint'(regs[REG_ACCEL_LIMIT]));
				rate = clip(raw_rate, -longint'(regs[REG_STEER_RATE_LIMIT]),
					longint'(regs[REG_STEER_RATE_LIMIT]));
				if (acc != raw_acc || rate != raw_rate)
					n_clamped++;
			end else begin
				n_invalid++;
			end
			if (s.brake_button)
				n_brake++;
			c.accel_cmd      = acc[15:0];
			c.steer_rate_cmd = rate[15:0];
			c.brake_active   = s.brake_button;
			return c;
		endfunction

		function void note_stick(stick_t s);
			expected_cmds.push_back(predict_command(s));
			n_sets++;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_drive(drive_t got);
			drive_t want;
			if (expected_cmds.size() == 0) begin
				report_mismatch($sformatf("command with none expected: accel %0d rate %0d",
					$signed(got.accel_cmd), $signed(got.steer_rate_cmd)));
				return;
			end
			want = expected_cmds.pop_front();
			if (got.accel_cmd !== want.accel_cmd)
				report_mismatch($sformatf("accel_cmd got %0d want %0d",
					$signed(got.accel_cmd), $signed(want.accel_cmd)));
			if (got.steer_rate_cmd !== want.steer_rate_cmd)
				report_mismatch($sformatf("steer_rate_cmd got %0d want %0d",
					$signed(got.steer_rate_cmd), $signed(want.steer_rate_cmd)));
			if (got.brake_active !== want.brake_active)
				report_mismatch($sformatf("brake_active got %b want %b",
					got.brake_active, want.brake_active));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Signals and instance
	// ------------------------------------------------------------------------
	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      stick_valid;
	logic                      stick_stall;
	stick_t                    stick;
	logic                      drive_valid;
	logic                      drive_stall;
	drive_t                    drive;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	drive_command_scoreboard #(GAIN_FRAC) sb;

	// Idle control, changed per phase by the stimulus process
	int          gap_pct;
	int          stall_pct;
	bit          hold_req;
	int          n_holds;
	int          n_backpressure;
	int          n_phases;
	logic [15:0] cfg_plan [8];

	stick_to_drive_command_unit #(
		.GAIN_FRAC_BITS(GAIN_FRAC)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.stick_valid (stick_valid),
		.stick_stall (stick_stall),
		.stick       (stick),
		.drive_valid (drive_valid),
		.drive_stall (drive_stall),
		.drive       (drive),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: note each input transfer, check each output transfer. Both are
	// sampled at the rising edge, before the unit's own updates land.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (stick_valid && !stick_stall)
				sb.note_stick(stick);
			if (stick_valid && stick_stall)
				n_backpressure++;
			if (drive_valid && !drive_stall)
				sb.check_drive(drive);
		end
	end

	// Gap length for either side: mostly short, now and then long
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 2);
		if (r < 9)
			return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request. The hold is
	// counted here, in cycles, independent of the sender.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int stall_left;
		stall_left  = 0;
		drive_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				n_holds++;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && stall_pct > 0
					&& $urandom_range(0, 99) < stall_pct) begin
				stall_left = rand_gap();
			end
			if (stall_left > 0) begin
				stall_left--;
				drive_stall <= 1'b1;
			end else begin
				drive_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender side helpers
	// ------------------------------------------------------------------------
	function automatic stick_t mk_stick(int spd, int str, bit brk, bit ok, int lim,
			int ms, int mst);
		stick_t s;
		s.speed_stick    = 16'(spd);
		s.steer_stick    = 16'(str);
		s.brake_button   = brk;
		s.axes_valid     = ok;
		s.speed_limit    = 15'(lim);
		s.measured_speed = 16'(ms);
		s.measured_steer = 16'(mst);
		return s;
	endfunction

	// Stick value: extremes, the deadzone edge, or anything at all
	function automatic logic [15:0] rand_axis(longint dz);
		int edge_val;
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h8001;
			3: return 16'h0000;
			4, 5: begin
				edge_val = int'(dz) + $urandom_range(0, 4) - 2;
				if (edge_val < 0)
					edge_val = 0;
				if (edge_val > 32767)
					edge_val = 32767;
				return $urandom_range(0, 1) ? 16'(-edge_val) : 16'(edge_val);
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Measured value: usually near the working range so that not every
	// command sits on a clamp, sometimes anywhere
	function automatic logic [15:0] rand_measure();
		if ($urandom_range(0, 2) == 0)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 2048)) - 1024);
	endfunction

	function automatic stick_t rand_stick();
		stick_t s;
		longint dz;
		dz = sb.clamped_deadzone();
		s.speed_stick    = rand_axis(dz);
		s.steer_stick    = rand_axis(dz);
		s.brake_button   = ($urandom_range(0, 3) == 0);
		s.axes_valid     = ($urandom_range(0, 9) != 0);
		s.speed_limit    = ($urandom_range(0, 7) == 0) ? 15'($urandom_range(0, 1) * 32767)
			: 15'($urandom);
		s.measured_speed = rand_measure();
		s.measured_steer = rand_measure();
		return s;
	endfunction

	// Register value: zero, all ones (masked or clamped by the unit), raw
	// random, or a moderate value that keeps commands off the clamps
	function automatic logic [15:0] rand_reg_value(cfg_reg_t idx);
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h0000;
			1: v = 16'hFFFF;
			2: v = 16'($urandom);
			default: begin
				if (idx == REG_SPEED_GAIN || idx == REG_STEER_GAIN) begin
					v = 16'($urandom_range(16, 1024));
				end else begin
					if (idx == REG_DEADZONE)
						v = 16'($urandom_range(0, 9830));
					else
						v = 16'($urandom_range(64, 8192));
					// top bit is dropped by the unit, exercise it anyway
					v[15] = $urandom_range(0, 1);
				end
			end
		endcase
		return v;
	endfunction

	// Offer one sample set; hold it until transferred, then maybe idle.
	// Entered and left at a falling edge.
	task automatic offer_stick(stick_t s);
		int gap;
		stick       <= s;
		stick_valid <= 1'b1;
		do
			@(posedge clk);
		while (stick_stall);
		@(negedge clk);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = rand_gap();
			stick_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Wait until every expected command has arrived
	task automatic wait_drained();
		while (sb.pending() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write all eight registers from cfg_plan, back to back
	task automatic apply_plan();
		for (int i = 0; i < 8; i++) begin
			cfg_index <= CFG_INDEX_BITS'(i);
			cfg_data  <= cfg_plan[i];
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			sb.set_reg(cfg_reg_t'(i), cfg_plan[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int count, bit pause_midway);
		for (int i = 0; i < count; i++) begin
			// sender pause: drop valid and let the pipeline run dry
			if (pause_midway && i == count / 2) begin
				stick_valid <= 1'b0;
				wait_drained();
			end
			offer_stick(rand_stick());
		end
		stick_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		sb             = new();
		arst_n         = 1'b0;
		stick_valid    = 1'b0;
		stick          = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_DEADZONE;
		cfg_data       = '0;
		gap_pct        = 30;
		stall_pct      = 30;
		hold_req       = 1'b0;
		n_holds        = 0;
		n_backpressure = 0;
		n_phases       = 1;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed sets at the reset register values (deadzone 3277)
		offer_stick(mk_stick(0, 0, 0, 1, 0, 0, 0));
		offer_stick(mk_stick(-32768, -32768, 0, 1, 32767, 0, 0));
		offer_stick(mk_stick(32767, 32767, 0, 1, 32767, 0, 0));
		offer_stick(mk_stick(-32767, 32767, 0, 1, 32767, -32768, 32767));
		// right on the deadzone edge, then one past it
		offer_stick(mk_stick(3277, -3277, 0, 1, 32767, 0, 0));
		offer_stick(mk_stick(3278, -3278, 0, 1, 32767, 0, 0));
		offer_stick(mk_stick(-3278, 3278, 0, 1, 20000, 100, -100));
		offer_stick(mk_stick(1000, -1000, 0, 1, 32767, 1, -1));
		// braking: target speed forced to zero, brake decel clamp
		offer_stick(mk_stick(-32768, 0, 1, 1, 32767, 0, 0));
		offer_stick(mk_stick(-32768, 0, 1, 1, 32767, 32767, 0));
		offer_stick(mk_stick(32767, 0, 0, 1, 32767, 32767, 0));
		offer_stick(mk_stick(-32768, -32768, 1, 1, 0, -32768, -32768));
		offer_stick(mk_stick(32767, 32767, 1, 1, 32767, 32767, 32767));
		// axes invalid: zero command, brake still reported
		offer_stick(mk_stick(0, 0, 0, 0, 32767, -32768, -32768));
		offer_stick(mk_stick(-32768, 32767, 1, 0, 32767, 32767, 32767));
		// zero speed limit, measured extremes, mid-range values
		offer_stick(mk_stick(-16384, 16384, 0, 1, 0, -300, 300));
		offer_stick(mk_stick(16384, -16384, 0, 1, 12800, -32768, 32767));
		offer_stick(mk_stick(-20000, 8000, 0, 1, 25600, 400, -500));
		stick_valid <= 1'b0;
		wait_drained();

		// All ones: deadzone above its ceiling, full gains and limits
		for (int i = 0; i < 8; i++)
			cfg_plan[i] = 16'hFFFF;
		apply_plan();
		n_phases++;
		run_random(60, 1'b0);
		wait_drained();

		// All zero: no deadzone, zero gains, every clamp shut
		for (int i = 0; i < 8; i++)
			cfg_plan[i] = 16'h0000;
		apply_plan();
		n_phases++;
		run_random(40, 1'b0);
		wait_drained();

		// Random settings; vary the idling, one phase under a long hold-off
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < 8; i++)
				cfg_plan[i] = rand_reg_value(cfg_reg_t'(i));
			apply_plan();
			n_phases++;
			if (p == 2) begin
				// receiver holds off while the sender streams: fill the pipe
				gap_pct   = 0;
				stall_pct = 0;
				hold_req  = 1'b1;
			end else if (p % 3 == 0) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(10, 50);
				stall_pct = $urandom_range(10, 50);
			end
			run_random(PHASE_ITEMS, p == 4);
			wait_drained();
		end

		// Drain, then let any late or stray command show up
		stick_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		$display("Ran %0d sample sets over %0d register settings: %0d braking, %0d with axes invalid, %0d at a clamp",
			sb.n_sets, n_phases, sb.n_brake, sb.n_invalid, sb.n_clamped);
		$display("Receiver hold-offs: %0d, input back-pressure cycles: %0d, mismatches: %0d",
			n_holds, n_backpressure, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: a hung handshake ends the run here
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Timeout with %0d commands outstanding", sb.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
src/sdc_pkg.sv
src/stick_to_drive_command_unit.sv
src/sdc_checker.sv
dv/stick_to_drive_command_unit_tb.sv
